### src/slt_pkg.sv
`timescale 1ns / 1ps

package slt_pkg;

  typedef enum logic [4:0] {
    KIND_IDENT   = 5'd0,
    KIND_INT     = 5'd1,
    KIND_STRING  = 5'd2,
    KIND_SELECT  = 5'd3,
    KIND_INSERT  = 5'd4,
    KIND_INTO    = 5'd5,
    KIND_FROM    = 5'd6,
    KIND_WHERE   = 5'd7,
    KIND_VALUES  = 5'd8,
    KIND_BETWEEN = 5'd9,
    KIND_AND     = 5'd10,
    KIND_STAR    = 5'd11,
    KIND_COMMA   = 5'd12,
    KIND_LPAREN  = 5'd13,
    KIND_RPAREN  = 5'd14,
    KIND_EQ      = 5'd15,
    KIND_SEMI    = 5'd16,
    KIND_END     = 5'd17,
    KIND_BADCHAR = 5'd18,
    KIND_UNTERM  = 5'd19
  } kind_e;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_WORD = 5'b00010,
    MODE_NUM  = 5'b00100,
    MODE_STR  = 5'b01000,
    MODE_SKIP = 5'b10000
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] line;
    logic [15:0] start;
    logic [7:0]  len;
  } tok_t;

  // up to two tokens caused by one byte
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0]  LEN_MAX  = 8'd255;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  // keyword text, last character in the low byte
  localparam logic [63:0] KW_TEXT [8] = '{
    64'("SELECT"), 64'("INSERT"), 64'("INTO"), 64'("FROM"),
    64'("WHERE"), 64'("VALUES"), 64'("BETWEEN"), 64'("AND")
  };
  localparam logic [2:0] KW_LEN [8] = '{
    3'd6, 3'd6, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7, 3'd3
  };

endpackage

### src/slt_front.sv
`timescale 1ns / 1ps

module slt_front #(
  parameter int POS_BITS = 16,
  parameter int WORD_MAX = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        ch_i,
  input  logic              end_marker_i,
  output logic              push_o,
  output slt_pkg::bundle_t  bundle_o
);
  import slt_pkg::*;

  localparam logic [7:0]          WMAX    = 8'(WORD_MAX);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] kw_step(input logic [7:0] alive, input logic [7:0] len,
                                         input logic [7:0] up);
    logic [7:0] res;
    logic [2:0] idx;
    res = alive;
    for (int k = 0; k < 8; k++) begin
      idx = KW_LEN[k] - 3'd1 - len[2:0];
      if ((len >= {5'd0, KW_LEN[k]}) || (up != KW_TEXT[k][{idx, 3'b000} +: 8])) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic kind_e word_kind(input logic [7:0] alive, input logic [7:0] len);
    kind_e res;
    res = KIND_IDENT;
    for (int k = 7; k >= 0; k--) begin
      if (alive[k] && len == {5'd0, KW_LEN[k]}) begin
        res = kind_e'(5'(KIND_SELECT) + 5'(k));
      end
    end
    return res;
  endfunction

  function automatic tok_t mk_tok(input kind_e kind, input logic [15:0] line,
                                  input logic [POS_BITS-1:0] start, input logic [7:0] len);
    tok_t t;
    logic [31:0] w;
    w = 32'(start);
    t.kind = kind;
    t.line = line;
    t.start = (|w[31:16]) ? 16'hFFFF : w[15:0];
    t.len = len;
    return t;
  endfunction

  mode_e               mode_q, mode_d;
  logic [15:0]         line_q, line_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] tstart_q, tstart_d;
  logic [7:0]          tlen_q, tlen_d;
  logic [15:0]         tline_q, tline_d;
  logic [7:0]          alive_q, alive_d;

  logic       fin;
  logic [7:0] up;

  // response of a byte seen outside any token
  mode_e               ib_mode;
  logic                ib_start;
  logic                ib_emit;
  kind_e               ib_kind;
  logic [15:0]         ib_line;
  logic [POS_BITS-1:0] ib_tstart;
  logic [7:0]          ib_tlen;
  logic [7:0]          ib_alive;

  logic a_vld, b_vld, run_idle;
  tok_t a_tok, b_tok;

  assign fin = end_marker_i || (ch_i == 8'd0);
  assign up  = (ch_i >= "a" && ch_i <= "z") ? ch_i - 8'd32 : ch_i;

  always_comb begin
    ib_mode   = MODE_IDLE;
    ib_start  = 1'b0;
    ib_emit   = 1'b0;
    ib_kind   = KIND_BADCHAR;
    ib_line   = line_q;
    ib_tstart = pos_q;
    ib_tlen   = 8'd0;
    ib_alive  = 8'hFF;
    if (is_space(ch_i)) begin
      if (ch_i == 8'h0A && line_q != LINE_MAX) begin
        ib_line = line_q + 16'd1;
      end
    end else if (is_alpha(ch_i) || ch_i == "_") begin
      ib_mode  = MODE_WORD;
      ib_start = 1'b1;
      ib_tlen  = 8'd1;
      ib_alive = kw_step(8'hFF, 8'd0, up);
    end else if (is_digit(ch_i)) begin
      ib_mode  = MODE_NUM;
      ib_start = 1'b1;
      ib_tlen  = 8'd1;
    end else if (ch_i == "'") begin
      ib_mode   = MODE_STR;
      ib_start  = 1'b1;
      ib_tstart = (pos_q != POS_MAX) ? pos_q + 1'b1 : POS_MAX;
    end else begin
      ib_emit = 1'b1;
      case (ch_i)
        "*":     ib_kind = KIND_STAR;
        ",":     ib_kind = KIND_COMMA;
        "(":     ib_kind = KIND_LPAREN;
        ")":     ib_kind = KIND_RPAREN;
        "=":     ib_kind = KIND_EQ;
        ";":     ib_kind = KIND_SEMI;
        default: begin
          ib_kind = KIND_BADCHAR;
          ib_mode = MODE_SKIP;
        end
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    pos_d    = pos_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    tline_d  = tline_q;
    alive_d  = alive_q;
    a_vld    = 1'b0;
    b_vld    = 1'b0;
    a_tok    = mk_tok(word_kind(alive_q, tlen_q), tline_q, tstart_q, tlen_q);
    b_tok    = mk_tok(ib_kind, line_q, pos_q, 8'd1);
    run_idle = 1'b0;
    if (acc_i) begin
      if (mode_q == MODE_SKIP || fin) begin
        if (fin) begin
          if (mode_q == MODE_STR) begin
            a_vld = 1'b1;
            a_tok = mk_tok(KIND_UNTERM, tline_q, tstart_q, tlen_q);
          end else if (mode_q != MODE_SKIP) begin
            a_vld = (mode_q == MODE_WORD) || (mode_q == MODE_NUM);
            if (mode_q == MODE_NUM) begin
              a_tok = mk_tok(KIND_INT, tline_q, tstart_q, tlen_q);
            end
            b_vld = 1'b1;
            b_tok = mk_tok(KIND_END, line_q, pos_q, 8'd0);
          end
          mode_d   = MODE_IDLE;
          line_d   = 16'd1;
          pos_d    = '0;
          tstart_d = '0;
          tlen_d   = 8'd0;
          tline_d  = 16'd1;
          alive_d  = 8'hFF;
        end
      end else begin
        case (mode_q)
          MODE_WORD: begin
            if (is_alpha(ch_i) || is_digit(ch_i) || ch_i == "_") begin
              if (tlen_q < WMAX) begin
                alive_d = kw_step(alive_q, tlen_q, up);
                tlen_d  = tlen_q + 8'd1;
              end
            end else begin
              a_vld    = 1'b1;
              run_idle = 1'b1;
            end
          end
          MODE_NUM: begin
            if (is_digit(ch_i)) begin
              if (tlen_q != LEN_MAX) begin
                tlen_d = tlen_q + 8'd1;
              end
            end else begin
              a_vld    = 1'b1;
              a_tok    = mk_tok(KIND_INT, tline_q, tstart_q, tlen_q);
              run_idle = 1'b1;
            end
          end
          MODE_STR: begin
            if (ch_i == "'") begin
              a_vld  = 1'b1;
              a_tok  = mk_tok(KIND_STRING, tline_q, tstart_q, tlen_q);
              mode_d = MODE_IDLE;
            end else if (tlen_q != LEN_MAX) begin
              tlen_d = tlen_q + 8'd1;
            end
          end
          default: run_idle = 1'b1;
        endcase
        if (run_idle) begin
          mode_d = ib_mode;
          line_d = ib_line;
          b_vld  = ib_emit;
          if (ib_start) begin
            tstart_d = ib_tstart;
            tlen_d   = ib_tlen;
            tline_d  = line_q;
            alive_d  = ib_alive;
          end
        end
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_o        = a_vld || b_vld;
    bundle_o.tok0 = a_vld ? a_tok : b_tok;
    bundle_o.tok1 = b_tok;
    bundle_o.two  = a_vld && b_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      line_q   <= 16'd1;
      pos_q    <= '0;
      tstart_q <= '0;
      tlen_q   <= 8'd0;
      tline_q  <= 16'd1;
      alive_q  <= 8'hFF;
    end else begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      tline_q  <= tline_d;
      alive_q  <= alive_d;
    end
  end

endmodule

### src/slt_queue.sv
`timescale 1ns / 1ps

module slt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  slt_pkg::bundle_t    wdata_i,
  input  logic                pop_i,
  output slt_pkg::bundle_t    rdata_o,
  output slt_pkg::q_status_t  status_o
);
  import slt_pkg::*;

  bundle_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;

  logic do_push, do_pop;

  assign status_o.full  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/slt_back.sv
`timescale 1ns / 1ps

module slt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slt_pkg::bundle_t    rdata_i,
  input  slt_pkg::q_status_t  status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [4:0]          kind_o,
  output logic [15:0]         line_no_o,
  output logic [15:0]         start_pos_o,
  output logic [7:0]          length_o,
  output logic                last_of_run_o
);
  import slt_pkg::*;

  tok_t out_q, sec_q;
  logic out_last_q, out_vld_q, sec_vld_q;
  logic load;

  assign load  = !out_vld_q || !out_stall_i;
  assign pop_o = load && !sec_vld_q && !status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_vld_q <= 1'b0;
    end else if (load) begin
      if (sec_vld_q) begin
        out_vld_q <= 1'b1;
        sec_vld_q <= 1'b0;
      end else begin
        out_vld_q <= !status_i.empty;
        sec_vld_q <= !status_i.empty && rdata_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_vld_q) begin
        out_q      <= sec_q;
        out_last_q <= 1'b1;
      end else begin
        out_q      <= rdata_i.tok0;
        out_last_q <= !rdata_i.two;
        sec_q      <= rdata_i.tok1;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign kind_o        = out_q.kind;
  assign line_no_o     = out_q.line;
  assign start_pos_o   = out_q.start;
  assign length_o      = out_q.len;
  assign last_of_run_o = out_last_q;

endmodule

### src/sql_keyword_tokenizer.sv
`timescale 1ns / 1ps

// channel  | handshake                 | payload
// ---------+---------------------------+----------------------------------------------
// input    | in_valid_i / in_stall_o   | ch_i, end_marker_i
// output   | out_valid_o / out_stall_i | kind_o, line_no_o, start_pos_o, length_o,
//          |                           | last_of_run_o
//
// One byte is taken every cycle unless in_stall_o is high; the lexer state updates in the
// cycle of acceptance. A token goes through the queue into the output register before it
// is valid; a byte giving two tokens sends them in turn, one token per cycle unless stalled.
// A four-entry token queue sits between lexer and output; in_stall_o rises when it fills.
// Reset clears lexer state, empties the queue and clears the output valid flags.

module sql_keyword_tokenizer #(
  parameter int POS_BITS = 16,
  parameter int WORD_MAX = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        end_marker_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  kind_o,
  output logic [15:0] line_no_o,
  output logic [15:0] start_pos_o,
  output logic [7:0]  length_o,
  output logic        last_of_run_o
);
  import slt_pkg::*;

  logic      acc, push, pop;
  bundle_t   wbundle, rbundle;
  q_status_t qstat;

  assign in_stall_o = qstat.full;
  assign acc        = in_valid_i && !qstat.full;

  slt_front #(
    .POS_BITS(POS_BITS),
    .WORD_MAX(WORD_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .ch_i        (ch_i),
    .end_marker_i(end_marker_i),
    .push_o      (push),
    .bundle_o    (wbundle)
  );

  slt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbundle),
    .pop_i   (pop),
    .rdata_o (rbundle),
    .status_o(qstat)
  );

  slt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rdata_i      (rbundle),
    .status_i     (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .line_no_o    (line_no_o),
    .start_pos_o  (start_pos_o),
    .length_o     (length_o),
    .last_of_run_o(last_of_run_o)
  );

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  // two tokens from one byte: the first is always a finished word or number
  a_pair_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && wbundle.two) |-> (wbundle.tok0.kind <= KIND_AND))
    else $error("token pair does not start with a word or number");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == 5'(KIND_END)) |-> last_of_run_o)
    else $error("end token not marked last");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
